[hdl/amm_pkg.sv]
`default_nettype none

package amm_pkg;

	localparam int NUM_IN  = 16;
	localparam int NUM_OUT = 16;
	localparam int RUN_LEN = NUM_OUT + 3;
	localparam int RUN_W   = $clog2(RUN_LEN + 1);

	localparam logic [1:0] MODE_GAIN   = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] CFG_ACT_IN  = 2'd0;
	localparam logic [1:0] CFG_ACT_OUT = 2'd1;
	localparam logic [1:0] CFG_INTERP  = 2'd2;
	localparam logic [1:0] CFG_VLOG    = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [3:0]  in_index;
		logic [15:0] smp;
		logic [7:0]  pos;
		logic        ramp;
		logic [3:0]  k;
	} tok_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  in_index;
		logic [3:0]  out_index;
		logic [15:0] gain;
	} gwr_t;

	typedef struct packed {
		logic       clr_gains;
		logic       load;
		logic       commit;
		logic       shift;
		logic [4:0] ni;
		logic [4:0] nout;
	} cctl_t;

endpackage

`default_nettype wire

[hdl/audio_matrix_mixer_unit.sv]
// channel  | dir | tdata fields (lsb first)                         | tlast
// s_       | in  | mode[2] in_index[4] out_index[4] gain[16]         | frame_end
//          |     | sample[16], zero pad to 48                        |
// m_       | out | out_channel[4] out_sample[16], zero pad to 24      | last
// cfg_     | in  | cfg_index selects register, cfg_data holds value  | -
//
// Gain write and gain clear words are taken without leaving the idle state.
// A sample word blocks input while it travels the 16-cell chain one cell per
// cycle, and each cell has three stages (gain select, ramp scale, accumulate).
// A frame end adds a load state, held until the previous frame's outputs
// are all taken; words leave cell 0, one per cycle while m_tready is high.
// Reset clears all gains, accumulators, counters and ramp flags at once.
`default_nettype none

module audio_matrix_mixer_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // mode, in_index, out_index, gain, sample
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // out_channel, out_sample
	output logic        m_tlast,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [4:0]  cfg_data
);
	import amm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t           state_q;
	logic [RUN_W-1:0] run_cnt_q;
	logic             fe_q;
	logic [4:0]       act_in_q;
	logic [4:0]       act_out_q;
	logic             interp_q;
	logic [3:0]       vlog_q;
	logic [7:0]       fiv_q;
	logic             pend_q;
	logic             ramp_q;
	logic             busy_q;
	logic [3:0]       idx_q;
	logic [4:0]       num_q;
	tok_t             tok_q;

	logic [1:0]  f_mode;
	logic [3:0]  f_in;
	logic [3:0]  f_out;
	logic [15:0] f_gain;
	logic [15:0] f_smp;
	logic        in_acc;
	logic        out_acc;
	logic [4:0]  ni;
	logic [4:0]  nout;
	logic [3:0]  k;
	logic [8:0]  vlen;
	logic [7:0]  pos;
	logic        ramp_now;
	logic [7:0]  fiv_nxt;
	logic        wrap;
	gwr_t        gwr;
	cctl_t       ctl;

	tok_t        tok_c [NUM_OUT+1];
	logic [15:0] smp_c [NUM_OUT+1];

	assign f_mode = s_tdata[1:0];
	assign f_in   = s_tdata[5:2];
	assign f_out  = s_tdata[9:6];
	assign f_gain = s_tdata[25:10];
	assign f_smp  = s_tdata[41:26];

	assign s_tready = state_q == ST_IDLE;
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;

	assign ni   = (act_in_q > 5'(NUM_IN)) ? 5'(NUM_IN) : act_in_q;
	assign nout = (act_out_q > 5'(NUM_OUT)) ? 5'(NUM_OUT) : act_out_q;
	assign k    = (vlog_q > 4'd8) ? 4'd8 : vlog_q;
	assign vlen = 9'd1 << k;
	assign pos  = ({1'b0, fiv_q} < vlen) ? fiv_q : 8'(vlen - 9'd1);

	assign ramp_now = ramp_q || (fiv_q == 8'd0 && pend_q);
	assign fiv_nxt  = fiv_q + 8'd1;
	assign wrap     = ({1'b0, fiv_nxt} >= vlen) || fiv_nxt == 8'd0;

	assign gwr.en        = in_acc && f_mode == MODE_GAIN;
	assign gwr.in_index  = f_in;
	assign gwr.out_index = f_out;
	assign gwr.gain      = f_gain;

	assign ctl.clr_gains = in_acc && f_mode == MODE_CLEAR;
	assign ctl.load      = state_q == ST_LOAD && !busy_q;
	assign ctl.commit    = ctl.load && wrap && ramp_q;
	assign ctl.shift     = out_acc;
	assign ctl.ni        = ni;
	assign ctl.nout      = nout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_in_q  <= 5'd1;
			act_out_q <= 5'd1;
			interp_q  <= 1'b0;
			vlog_q    <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACT_IN:  act_in_q  <= cfg_data;
				CFG_ACT_OUT: act_out_q <= cfg_data;
				CFG_INTERP:  interp_q  <= cfg_data[0];
				CFG_VLOG:    vlog_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_cnt_q <= '0;
			fe_q      <= 1'b0;
			fiv_q     <= '0;
			pend_q    <= 1'b0;
			ramp_q    <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q.valid <= in_acc && f_mode == MODE_SAMPLE && ({1'b0, f_in} < ni);
			if (in_acc) begin
				tok_q.in_index <= f_in;
				tok_q.smp      <= f_smp;
				tok_q.pos      <= pos;
				tok_q.ramp     <= ramp_now;
				tok_q.k        <= k;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && f_mode == MODE_GAIN && interp_q)
						pend_q <= 1'b1;
					if (in_acc && f_mode == MODE_SAMPLE) begin
						if (fiv_q == 8'd0 && pend_q) begin
							pend_q <= 1'b0;
							ramp_q <= 1'b1;
						end
						fe_q        <= s_tlast;
						run_cnt_q   <= RUN_W'(RUN_LEN);
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (run_cnt_q == '0)
						state_q <= fe_q ? ST_LOAD : ST_IDLE;
					else
						run_cnt_q <= run_cnt_q - RUN_W'(1);
				end
				ST_LOAD: begin
					if (!busy_q) begin
						fiv_q <= wrap ? 8'd0 : fiv_nxt;
						if (wrap)
							ramp_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			num_q  <= '0;
		end else if (ctl.load) begin
			busy_q <= nout != 5'd0;
			idx_q  <= '0;
			num_q  <= nout;
		end else if (out_acc) begin
			if (m_tlast)
				busy_q <= 1'b0;
			idx_q <= idx_q + 4'd1;
		end
	end

	assign tok_c[0]       = tok_q;
	assign smp_c[NUM_OUT] = '0;

	for (genvar c = 0; c < NUM_OUT; c++) begin : g_cell
		amm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (4'(c)),
			.tok_in     (tok_c[c]),
			.tok_out    (tok_c[c+1]),
			.gwr        (gwr),
			.ctl        (ctl),
			.shift_in   (smp_c[c+1]),
			.out_sample (smp_c[c])
		);
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = {1'b0, idx_q} == num_q - 5'd1;
	assign m_tdata  = {4'd0, smp_c[0], idx_q};

endmodule

`default_nettype wire

[hdl/amm_cell.sv]
`default_nettype none

module amm_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [3:0]          cell_idx,
	input  amm_pkg::tok_t       tok_in,
	output amm_pkg::tok_t       tok_out,
	input  amm_pkg::gwr_t       gwr,
	input  amm_pkg::cctl_t      ctl,
	input  wire  [15:0]         shift_in,
	output logic [15:0]         out_sample
);
	import amm_pkg::*;

	logic signed [15:0] tab_q  [NUM_IN];
	logic signed [15:0] prev_q [NUM_IN];

	tok_t               tok_s1;
	logic signed [15:0] g_s1;
	logic signed [15:0] prev_s1;
	logic signed [26:0] prod_s1;
	logic               v_s2;
	logic signed [31:0] mul_s2;
	logic signed [39:0] acc_q;
	logic        [15:0] out_q;

	logic               active;
	logic signed [16:0] diff;
	logic signed [9:0]  pfac;
	logic signed [26:0] prod_c;
	logic signed [26:0] shft;
	logic signed [16:0] geff17;
	logic signed [15:0] geff;
	logic signed [31:0] mul_c;
	logic signed [40:0] sum41;
	logic signed [40:0] rnd41;
	logic signed [40:0] y41;
	logic        [15:0] y16;

	assign active  = {1'b0, cell_idx} < ctl.nout;
	assign tok_out = tok_s1;

	assign diff   = {tab_q[tok_in.in_index][15], tab_q[tok_in.in_index]}
	              - {prev_q[tok_in.in_index][15], prev_q[tok_in.in_index]};
	assign pfac   = $signed({1'b0, {1'b0, tok_in.pos} + 9'd1});
	assign prod_c = diff * pfac;

	assign shft   = prod_s1 >>> tok_s1.k;
	assign geff17 = {prev_s1[15], prev_s1} + shft[16:0];
	assign geff   = tok_s1.ramp ? geff17[15:0] : g_s1;
	assign mul_c  = $signed(tok_s1.smp) * geff;

	assign sum41 = {acc_q[39], acc_q} + {{9{mul_s2[31]}}, mul_s2};

	assign rnd41 = {acc_q[39], acc_q} + 41'sd2048;
	assign y41   = rnd41 >>> 12;
	always_comb begin
		if (y41 > 41'sd32767)
			y16 = 16'h7fff;
		else if (y41 < -41'sd32768)
			y16 = 16'h8000;
		else
			y16 = y41[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IN; i++) begin
				tab_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else if (ctl.clr_gains) begin
			for (int i = 0; i < NUM_IN; i++) begin
				tab_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else begin
			if (gwr.en && gwr.out_index == cell_idx)
				tab_q[gwr.in_index] <= gwr.gain;
			if (ctl.commit && active) begin
				for (int i = 0; i < NUM_IN; i++) begin
					if (i < int'(ctl.ni))
						prev_q[i] <= tab_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			v_s2   <= 1'b0;
		end else begin
			tok_s1 <= tok_in;
			v_s2   <= tok_s1.valid && active;
		end
	end

	always_ff @(posedge clk) begin
		g_s1            <= tab_q[tok_in.in_index];
		prev_s1         <= prev_q[tok_in.in_index];
		prod_s1         <= prod_c;
		mul_s2          <= mul_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.load) begin
			acc_q <= '0;
		end else if (v_s2) begin
			if (sum41[40] != sum41[39])
				acc_q <= sum41[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
			else
				acc_q <= sum41[39:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			out_q <= y16;
		else if (ctl.shift)
			out_q <= shift_in;
	end

	assign out_sample = out_q;

endmodule

`default_nettype wire

[hdl/amm_chk.sv]
`default_nettype none

module amm_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [47:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tlast
);
	import amm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_chan_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[3:0] == 4'($past(m_tdata[3:0]) + 4'd1))
		else $error("output channels out of sequence");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[3:0] == 4'd0)
		else $error("frame does not open on channel zero");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == MODE_SAMPLE |=> !s_tready)
		else $error("sample word did not occupy the chain");

endmodule

bind audio_matrix_mixer_unit amm_chk u_amm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/sv/audio_matrix_mixer_unit_chk.sv]
`timescale 1ns / 1ps

module audio_matrix_mixer_unit_chk (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [47:0] s_tdata,   // mode, in_index, out_index, gain, sample
	input  wire         s_tlast,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [23:0] m_tdata,   // out_channel, out_sample
	input  wire         m_tlast,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [4:0]  cfg_data,
	output int          errors,
	output int          pending,
	output int          checked
);
	import amm_pkg::*;

	localparam longint ACC_HI = (longint'(1) <<< 39) - 1;
	localparam longint ACC_LO = -(longint'(1) <<< 39);

	typedef struct packed {
		logic [3:0]  ch;
		logic [15:0] smp;
		logic        last;
	} mix_out_t;

	mix_out_t           mix_due[$];
	logic signed [15:0] gain_mem [NUM_IN * NUM_OUT];
	logic signed [15:0] gain_was [NUM_IN * NUM_OUT];
	longint             mix_acc [NUM_OUT];
	logic [7:0]         frame_cnt;
	bit                 ramp_armed;
	bit                 ramp_on;
	logic [4:0]         act_in;
	logic [4:0]         act_out;
	logic               interp_on;
	logic [3:0]         vlog;

	task automatic flag(input string what, input int want, input int got);
		errors++;
		if (errors <= 40)
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	task automatic mix_word(input logic [47:0] d, input logic fe);
		logic [1:0]         mode;
		logic [3:0]         ii;
		logic [3:0]         oi;
		logic signed [15:0] g16;
		logic signed [15:0] s16;
		int                 k, vlen, nin, nout, pos, idx, o, a;
		longint             g, sum, y;
		mix_out_t           r;
		mode = d[1:0];
		ii   = d[5:2];
		oi   = d[9:6];
		g16  = d[25:10];
		s16  = d[41:26];
		k    = int'(vlog) > 8 ? 8 : int'(vlog);
		vlen = 1 << k;
		nin  = int'(act_in) > NUM_IN ? NUM_IN : int'(act_in);
		nout = int'(act_out) > NUM_OUT ? NUM_OUT : int'(act_out);
		case (mode)
			MODE_GAIN: begin
				gain_mem[int'(ii) * NUM_OUT + int'(oi)] = g16;
				if (interp_on)
					ramp_armed = 1'b1;
			end
			MODE_CLEAR: begin
				for (idx = 0; idx < NUM_IN * NUM_OUT; idx++) begin
					gain_mem[idx] = '0;
					gain_was[idx] = '0;
				end
			end
			MODE_SAMPLE: begin
				if (frame_cnt == 8'd0 && ramp_armed) begin
					ramp_armed = 1'b0;
					ramp_on    = 1'b1;
				end
				if (int'(ii) < nin) begin
					pos = int'(frame_cnt) < vlen ? int'(frame_cnt) : vlen - 1;
					for (o = 0; o < nout; o++) begin
						idx = int'(ii) * NUM_OUT + o;
						g   = longint'(gain_mem[idx]);
						if (ramp_on)
							g = longint'(gain_was[idx]) +
								(((g - longint'(gain_was[idx])) * longint'(pos + 1)) >>> k);
						sum = mix_acc[o] + longint'(s16) * g;
						if (sum > ACC_HI)
							sum = ACC_HI;
						if (sum < ACC_LO)
							sum = ACC_LO;
						mix_acc[o] = sum;
					end
				end
				if (fe) begin
					for (o = 0; o < nout; o++) begin
						y = (mix_acc[o] + 2048) >>> 12;
						if (y > 32767)
							y = 32767;
						if (y < -32768)
							y = -32768;
						r.ch   = o[3:0];
						r.smp  = y[15:0];
						r.last = (o + 1 == nout);
						mix_due.push_back(r);
					end
					for (o = 0; o < NUM_OUT; o++)
						mix_acc[o] = 0;
					frame_cnt = frame_cnt + 8'd1;
					if (int'(frame_cnt) >= vlen || frame_cnt == 8'd0) begin
						frame_cnt = '0;
						if (ramp_on) begin
							for (a = 0; a < nin; a++)
								for (o = 0; o < nout; o++)
									gain_was[a * NUM_OUT + o] = gain_mem[a * NUM_OUT + o];
							ramp_on = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		mix_out_t r;
		int       i;
		if (!arst_n) begin
			act_in     = 5'd1;
			act_out    = 5'd1;
			interp_on  = 1'b0;
			vlog       = 4'd6;
			frame_cnt  = '0;
			ramp_armed = 1'b0;
			ramp_on    = 1'b0;
			for (i = 0; i < NUM_IN * NUM_OUT; i++) begin
				gain_mem[i] = '0;
				gain_was[i] = '0;
			end
			for (i = 0; i < NUM_OUT; i++)
				mix_acc[i] = 0;
			mix_due.delete();
			errors  = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACT_IN:  act_in    = cfg_data;
					CFG_ACT_OUT: act_out   = cfg_data;
					CFG_INTERP:  interp_on = cfg_data[0];
					CFG_VLOG:    vlog      = cfg_data[3:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				mix_word(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (mix_due.size() == 0) begin
					errors++;
					if (errors <= 40)
						$display("%0t ns: output word with nothing due, channel %0d sample %0d",
							$time, m_tdata[3:0], $signed(m_tdata[19:4]));
				end else begin
					r = mix_due.pop_front();
					checked++;
					if (m_tdata[3:0] !== r.ch)
						flag("out_channel", int'(r.ch), int'(m_tdata[3:0]));
					if (m_tdata[19:4] !== r.smp)
						flag("out_sample", int'($signed(r.smp)), int'($signed(m_tdata[19:4])));
					if (m_tlast !== r.last)
						flag("last", int'(r.last), int'(m_tlast));
				end
			end
			pending = mix_due.size();
		end
	end

endmodule

[tb/sv/audio_matrix_mixer_unit_tb.sv]
`timescale 1ns / 1ps

module audio_matrix_mixer_unit_tb;
	import amm_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int         HOLD      = 64;
	localparam int         LIMIT     = 1000000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;   // mode, in_index, out_index, gain, sample
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // out_channel, out_sample
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data  = '0;

	int          errors, pending, checked;
	int          n_words  = 0;
	int          n_phases = 0;
	int          cycles   = 0;
	int          cur_ai   = 1;
	int          cur_ao   = 1;
	bit          calm     = 1'b0;

	audio_matrix_mixer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	audio_matrix_mixer_unit_chk i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles", cycles);
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rnd_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom);
		if (r < 75)
			return 16'($urandom_range(0, 4096) - 2048);
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0001;
			3: return 16'hFFFF;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic logic [15:0] rnd_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 16'($urandom_range(0, 8192) - 4096);
		if (r < 60)
			return 16'($urandom);
		if (r < 80)
			return 16'($urandom_range(0, 1024) - 512);
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h1000;
			3: return 16'hF000;
			default: return 16'h0000;
		endcase
	endfunction

	task automatic send(input logic [1:0] mode, input logic [3:0] ii, input logic [3:0] oi,
		input logic [15:0] gain, input logic [15:0] smp, input logic fe);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, smp, gain, oi, ii, mode};
		s_tlast  <= fe;
		do @(posedge clk); while (!s_tready);
		n_words++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	// drain, let the chain settle, then load all four registers
	task automatic setup(input logic [4:0] ai, input logic [4:0] ao,
		input logic [4:0] ip, input logic [4:0] vl);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (HOLD) @(posedge clk);
		write_reg(CFG_ACT_IN, ai);
		write_reg(CFG_ACT_OUT, ao);
		write_reg(CFG_INTERP, ip);
		write_reg(CFG_VLOG, vl);
		cfg_we <= 1'b0;
		cur_ai = int'(ai);
		cur_ao = int'(ao);
		n_phases++;
	endtask

	task automatic run_phase(input int n);
		int         sent, r, len, j, ispan, ospan;
		logic [3:0] ii, oi;
		sent  = 0;
		ispan = cur_ai > NUM_IN ? NUM_IN : (cur_ai == 0 ? 1 : cur_ai);
		ospan = cur_ao > NUM_OUT ? NUM_OUT : (cur_ao == 0 ? 1 : cur_ao);
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 22) begin
				oi = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, ospan - 1)) : 4'($urandom);
				ii = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, ispan - 1)) : 4'($urandom);
				send(MODE_GAIN, ii, oi, rnd_gain(), 16'($urandom), $urandom_range(0, 9) == 0);
				sent++;
			end else if (r < 24) begin
				send(MODE_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
				sent++;
			end else if (r < 28) begin
				send(MODE_NONE, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				len = $urandom_range(1, 6);
				for (j = 0; j < len; j++) begin
					ii = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, ispan - 1)) : 4'($urandom);
					send(MODE_SAMPLE, ii, 4'($urandom), 16'($urandom), rnd_sample(), j == len - 1);
					sent++;
				end
			end
		end
		send(MODE_SAMPLE, 4'd0, 4'($urandom), 16'($urandom), rnd_sample(), 1'b1);
	endtask

	initial begin : sink
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin : stim
		int p, j;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// rounding ties at reset settings
		send(MODE_GAIN, 4'd0, 4'd0, 16'h0800, 16'h0000, 1'b0);
		send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h0001, 1'b1);
		send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'hFFFF, 1'b1);

		setup(5'd16, 5'd16, 5'd0, 5'd0);
		send(MODE_GAIN, 4'd0, 4'd0, 16'h7FFF, 16'h0000, 1'b0);
		send(MODE_GAIN, 4'd0, 4'd1, 16'h8000, 16'h0000, 1'b0);
		send(MODE_GAIN, 4'd15, 4'd15, 16'h1000, 16'h0000, 1'b0);
		send(MODE_GAIN, 4'd1, 4'd0, 16'hF000, 16'h0000, 1'b0);
		send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h7FFF, 1'b0);
		send(MODE_SAMPLE, 4'd1, 4'd0, 16'h0000, 16'h8000, 1'b0);
		send(MODE_SAMPLE, 4'd15, 4'd0, 16'h0000, 16'h8000, 1'b1);
		send(MODE_NONE, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
		send(MODE_CLEAR, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b1);
		send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h3039, 1'b1);

		// short ramp from cleared gains
		setup(5'd16, 5'd16, 5'd1, 5'd1);
		send(MODE_GAIN, 4'd0, 4'd0, 16'h1000, 16'h0000, 1'b0);
		repeat (3) send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h4000, 1'b1);

		// shrink the vector while a ramp is part way through
		setup(5'd16, 5'd16, 5'd1, 5'd3);
		send(MODE_GAIN, 4'd0, 4'd0, 16'hF000, 16'h0000, 1'b0);
		repeat (5) send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h7FFF, 1'b1);
		setup(5'd16, 5'd16, 5'd1, 5'd1);
		repeat (2) send(MODE_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h7FFF, 1'b1);

		for (p = 0; p < 10; p++) begin
			case (p)
				0: setup(5'd1, 5'd1, 5'd0, 5'd8);
				1: setup(5'd16, 5'd16, 5'd1, 5'd0);
				2: setup(5'd31, 5'd17, 5'd31, 5'd15);
				3: setup(5'd0, 5'd4, 5'd1, 5'd2);
				4: setup(5'd5, 5'd0, 5'd0, 5'd4);
				default: begin
					j = $urandom_range(0, 9);
					setup(j == 0 ? 5'($urandom) : 5'($urandom_range(1, 16)),
						j == 1 ? 5'($urandom) : 5'($urandom_range(1, 16)),
						5'($urandom),
						$urandom_range(0, 9) < 7 ? 5'($urandom_range(0, 3)) : 5'($urandom));
				end
			endcase
			calm = ($urandom_range(0, 3) == 0);
			run_phase(26);
			calm = 1'b0;
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (HOLD) @(posedge clk);
		$display("Sent %0d input words over %0d register settings (ramps, saturation, noise)",
			n_words, n_phases);
		$display("Checked %0d mixed output words, %0d errors", checked, errors);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
hdl/amm_pkg.sv
hdl/amm_cell.sv
hdl/audio_matrix_mixer_unit.sv
hdl/amm_chk.sv
tb/sv/audio_matrix_mixer_unit_chk.sv
tb/sv/audio_matrix_mixer_unit_tb.sv
